/* rtl/cfbm_pkg.sv */
package cfbm_pkg;

  // sizing of the slot store and bundle
  localparam int NUM_SLOTS   = 8;
  localparam int MAX_CAMERAS = 4;

  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int MATCH_W   = $clog2(NUM_SLOTS + 1);
  localparam int CAM_IDX_W = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1;

  // fixed field widths
  localparam int STAMP_W    = 62;
  localparam int CAM_W      = 2;
  localparam int STATUS_W   = 3;
  localparam int MSLOT_W    = 3;
  localparam int SKIP_W     = 16;
  localparam int CCOUNT_W   = 3;
  localparam int CNT_W      = 4;
  localparam int SHIFT_W    = 32;
  localparam int WIN_W      = 30;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int ALU_W      = 64;

  // register reset values
  localparam logic [SKIP_W-1:0]   SKIP_FRAMES_RST  = '0;
  localparam logic [CCOUNT_W-1:0] CAMERA_COUNT_RST = 3'd1;
  localparam logic [SHIFT_W-1:0]  TIME_SHIFT_RST   = '0;
  localparam logic [WIN_W-1:0]    MATCH_WINDOW_RST = 30'd2000000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SKIP_FRAMES  = 2'd0,
    REG_CAMERA_COUNT = 2'd1,
    REG_TIME_SHIFT   = 2'd2,
    REG_MATCH_WINDOW = 2'd3
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_SKIPPED    = 3'd0,
    STATUS_STORED     = 3'd1,
    STATUS_MEMBER     = 3'd2,
    STATUS_FAILED     = 3'd3,
    STATUS_BAD_CAMERA = 3'd4
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  idx;
    logic [STAMP_W-1:0] stamp;
    logic [CAM_W-1:0]   camera;
  } slot_wr_t;

  typedef struct packed {
    logic               used;
    logic [STAMP_W-1:0] stamp;
    logic [CAM_W-1:0]   camera;
  } slot_rd_t;

  typedef struct packed {
    status_e             status;
    logic [CAM_W-1:0]    camera;
    logic [STAMP_W-1:0]  stamp;
    logic [MSLOT_W-1:0]  slot;
    logic [STAMP_W-1:0]  bstamp;
    logic                last;
  } result_t;

endpackage

/* rtl/cfbm_alu.sv */
module cfbm_alu (
  input  cfbm_pkg::alu_op_e          op_i,
  input  logic [cfbm_pkg::ALU_W-1:0] a_i,
  input  logic [cfbm_pkg::ALU_W-1:0] b_i,
  output logic [cfbm_pkg::ALU_W-1:0] sum_o
);
  import cfbm_pkg::*;

  logic [ALU_W-1:0] b_x;

  // subtract as a + ~b + 1
  assign b_x   = (op_i == ALU_SUB) ? ~b_i : b_i;
  assign sum_o = a_i + b_x + ALU_W'(op_i == ALU_SUB);

endmodule

/* rtl/cfbm_slots.sv */
module cfbm_slots (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfbm_pkg::slot_wr_t            wr_i,
  input  logic [cfbm_pkg::SLOT_W-1:0]   rd_idx_i,
  output cfbm_pkg::slot_rd_t            rd_o
);
  import cfbm_pkg::*;

  logic [STAMP_W-1:0]   stamp_q [NUM_SLOTS];
  logic [CAM_W-1:0]     camera_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] used_q;

  // used bits clear at reset, payload only matters once used
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (wr_i.en) begin
      used_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      stamp_q[wr_i.idx]  <= wr_i.stamp;
      camera_q[wr_i.idx] <= wr_i.camera;
    end
  end

  assign rd_o.used   = used_q[rd_idx_i];
  assign rd_o.stamp  = stamp_q[rd_idx_i];
  assign rd_o.camera = camera_q[rd_idx_i];

endmodule

/* rtl/camera_frame_bundle_matcher_core.sv */
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+----------------------------------
// cfg       | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
// in        | in        | in_valid_i / in_ready_o    | frame_stamp_i, camera_index_i
// out       | out       | out_valid_o / out_ready_i  | status_o, member_camera_o,
//           |           |                            | member_stamp_o, member_slot_o,
//           |           |                            | bundle_stamp_o, last_o
//
// a bad-camera or skipped frame passes idle and prep; any other frame passes prep, a slot
// search over 1..NUM_SLOTS slots, the write, a match walk over all NUM_SLOTS slots, decide
// and, for a full bundle, one emit step per member, and output stalls can hold prep, decide
// and emit; both slot walks go through the single 64-bit adder
// in_ready_o is high only in the idle state; the output register lets a new transfer in
// while the last result still waits on out_ready_i
// reset clears the slot used bits and the skip counter at once, no clearing pass
// cfg writes are taken every cycle and only expected while idle
module camera_frame_bundle_matcher_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [cfbm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [cfbm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // frame events
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cfbm_pkg::STAMP_W-1:0]      frame_stamp_i,
  input  logic [cfbm_pkg::CAM_W-1:0]        camera_index_i,
  // results
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [cfbm_pkg::STATUS_W-1:0]     status_o,
  output logic [cfbm_pkg::CAM_W-1:0]        member_camera_o,
  output logic [cfbm_pkg::STAMP_W-1:0]      member_stamp_o,
  output logic [cfbm_pkg::MSLOT_W-1:0]      member_slot_o,
  output logic [cfbm_pkg::STAMP_W-1:0]      bundle_stamp_o,
  output logic                              last_o
);
  import cfbm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_FIND,
    ST_WRITE,
    ST_MATCH,
    ST_DECIDE,
    ST_EMIT
  } state_e;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

  // configuration registers
  logic [SKIP_W-1:0]   skip_frames_q;
  logic [CCOUNT_W-1:0] camera_count_q;
  logic [SHIFT_W-1:0]  time_shift_q;
  logic [WIN_W-1:0]    match_window_q;

  // sequencer and per-frame context
  state_e                 state_q;
  logic [STAMP_W-1:0]     raw_q;
  logic [CAM_W-1:0]       cam_q;
  logic [STAMP_W-1:0]     stamp_q;
  logic [SKIP_W-1:0]      skipped_count_q;
  logic [SLOT_W-1:0]      idx_q;
  logic [SLOT_W-1:0]      sel_slot_q;
  logic [STAMP_W-1:0]     best_q;
  logic [MATCH_W-1:0]     matched_q;
  logic [MAX_CAMERAS-1:0] mvalid_q;
  logic [SLOT_W-1:0]      member_slot_q [MAX_CAMERAS];
  logic [STAMP_W-1:0]     member_stamp_q [MAX_CAMERAS];
  logic [CAM_IDX_W-1:0]   k_q;

  // output register
  logic    out_valid_q;
  result_t out_q;

  // shared adder
  alu_op_e          alu_op;
  logic [ALU_W-1:0] alu_a;
  logic [ALU_W-1:0] alu_b;
  logic [ALU_W-1:0] alu_sum;

  slot_wr_t slot_wr;
  slot_rd_t slot_rd;

  logic [CNT_W-1:0]   count_eff;
  logic [STAMP_W-1:0] sat_stamp;
  logic               bad_cam;
  logic               skip;
  logic [ALU_W-1:0]   nd;
  logic [WIN_W:0]     win_m1;
  logic               win_hit;
  logic               hit;
  logic               rd_cam_ok;
  logic [CAM_IDX_W-1:0] rd_cam_idx;
  logic               missing;
  logic               count_ok;
  logic               emit_last;
  logic               out_free;
  logic               res_want;
  logic               res_load;
  result_t            res_d;

  // --------------------------------------------------------------------------
  // configuration port, always ready
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_frames_q  <= SKIP_FRAMES_RST;
      camera_count_q <= CAMERA_COUNT_RST;
      time_shift_q   <= TIME_SHIFT_RST;
      match_window_q <= MATCH_WINDOW_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SKIP_FRAMES:  skip_frames_q  <= cfg_data_i[SKIP_W-1:0];
        REG_CAMERA_COUNT: camera_count_q <= cfg_data_i[CCOUNT_W-1:0];
        REG_TIME_SHIFT:   time_shift_q   <= cfg_data_i[SHIFT_W-1:0];
        REG_MATCH_WINDOW: match_window_q <= cfg_data_i[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // camera count clamped to 1..MAX_CAMERAS
  always_comb begin
    if (camera_count_q == '0) begin
      count_eff = CNT_W'(1);
    end else if (CNT_W'(camera_count_q) > CNT_W'(MAX_CAMERAS)) begin
      count_eff = CNT_W'(MAX_CAMERAS);
    end else begin
      count_eff = CNT_W'(camera_count_q);
    end
  end

  // --------------------------------------------------------------------------
  // shared adder: stamp shift in prep, stamp compare in find, distance in match
  // --------------------------------------------------------------------------
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = {2'b00, stamp_q};
    alu_b  = {2'b00, slot_rd.stamp};
    case (state_q)
      ST_PREP: begin
        alu_op = ALU_ADD;
        alu_a  = {2'b00, raw_q};
        alu_b  = {{(ALU_W - SHIFT_W){time_shift_q[SHIFT_W-1]}}, time_shift_q};
      end
      ST_FIND: begin
        alu_a = {2'b00, slot_rd.stamp};
        alu_b = {2'b00, best_q};
      end
      default: ;
    endcase
  end

  cfbm_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sum_o (alu_sum)
  );

  cfbm_slots u_slots (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (slot_wr),
    .rd_idx_i (idx_q),
    .rd_o     (slot_rd)
  );

  assign slot_wr.en     = (state_q == ST_WRITE);
  assign slot_wr.idx    = sel_slot_q;
  assign slot_wr.stamp  = stamp_q;
  assign slot_wr.camera = cam_q;

  // saturate the shifted stamp: negative goes to zero, overflow to the maximum
  always_comb begin
    if (alu_sum[ALU_W-1]) begin
      sat_stamp = '0;
    end else if (alu_sum[ALU_W-2]) begin
      sat_stamp = '1;
    end else begin
      sat_stamp = alu_sum[STAMP_W-1:0];
    end
  end

  assign bad_cam = CNT_W'(cam_q) >= count_eff;
  assign skip    = skipped_count_q < skip_frames_q;

  // window test on stamp_q - slot stamp; for a negative difference |d| = ~d + 1,
  // so |d| < w becomes ~d < w - 1
  assign nd     = ~alu_sum;
  assign win_m1 = {1'b0, match_window_q} - (WIN_W + 1)'(1);

  always_comb begin
    if (alu_sum[ALU_W-1]) begin
      win_hit = (match_window_q != '0) && (nd[ALU_W-1:WIN_W] == '0) &&
                ({1'b0, nd[WIN_W-1:0]} < win_m1);
    end else begin
      win_hit = (alu_sum[ALU_W-1:WIN_W] == '0) && (alu_sum[WIN_W-1:0] < match_window_q);
    end
  end

  assign hit        = slot_rd.used && win_hit;
  assign rd_cam_ok  = CNT_W'(slot_rd.camera) < count_eff;
  assign rd_cam_idx = CAM_IDX_W'(slot_rd.camera);

  // some camera below the count has no matching slot
  always_comb begin
    missing = 1'b0;
    for (int i = 0; i < MAX_CAMERAS; i++) begin
      if ((CNT_W'(i) < count_eff) && !mvalid_q[i]) begin
        missing = 1'b1;
      end
    end
  end

  assign count_ok  = 32'(matched_q) == 32'(count_eff);
  assign emit_last = CNT_W'(k_q) == (count_eff - CNT_W'(1));
  assign out_free  = !out_valid_q || out_ready_i;

  // --------------------------------------------------------------------------
  // result selection
  // --------------------------------------------------------------------------
  always_comb begin
    res_d    = '0;
    res_want = 1'b0;
    case (state_q)
      ST_PREP: begin
        if (bad_cam) begin
          res_want     = 1'b1;
          res_d.status = STATUS_BAD_CAMERA;
          res_d.last   = 1'b1;
        end else if (skip) begin
          res_want     = 1'b1;
          res_d.status = STATUS_SKIPPED;
          res_d.last   = 1'b1;
        end
      end
      ST_DECIDE: begin
        if (!count_ok) begin
          res_want     = 1'b1;
          res_d.status = STATUS_STORED;
          res_d.stamp  = stamp_q;
          res_d.slot   = MSLOT_W'(sel_slot_q);
          res_d.last   = 1'b1;
        end else if (missing) begin
          res_want     = 1'b1;
          res_d.status = STATUS_FAILED;
          res_d.last   = 1'b1;
        end
      end
      ST_EMIT: begin
        res_want     = 1'b1;
        res_d.status = STATUS_MEMBER;
        res_d.camera = CAM_W'(k_q);
        res_d.stamp  = member_stamp_q[k_q];
        res_d.slot   = MSLOT_W'(member_slot_q[k_q]);
        res_d.bstamp = member_stamp_q[0];
        res_d.last   = emit_last;
      end
      default: ;
    endcase
  end

  assign res_load = res_want && out_free;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      skipped_count_q <= '0;
      out_valid_q     <= 1'b0;
      idx_q           <= '0;
      k_q             <= '0;
    end else begin
      // a new result replaces the one leaving in the same cycle
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (bad_cam) begin
            if (out_free) begin
              state_q <= ST_IDLE;
            end
          end else if (skip) begin
            if (out_free) begin
              if (cam_q == '0) begin
                skipped_count_q <= skipped_count_q + SKIP_W'(1);
              end
              state_q <= ST_IDLE;
            end
          end else begin
            idx_q   <= '0;
            state_q <= ST_FIND;
          end
        end
        ST_FIND: begin
          // lowest free slot, else oldest stamp with the lowest index on a tie
          if (!slot_rd.used || (idx_q == SLOT_LAST)) begin
            state_q <= ST_WRITE;
          end else begin
            idx_q <= idx_q + SLOT_W'(1);
          end
        end
        ST_WRITE: begin
          idx_q   <= '0;
          state_q <= ST_MATCH;
        end
        ST_MATCH: begin
          if (idx_q == SLOT_LAST) begin
            state_q <= ST_DECIDE;
          end else begin
            idx_q <= idx_q + SLOT_W'(1);
          end
        end
        ST_DECIDE: begin
          if (res_want) begin
            if (out_free) begin
              state_q <= ST_IDLE;
            end
          end else begin
            k_q     <= '0;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (emit_last) begin
              state_q <= ST_IDLE;
            end else begin
              k_q <= k_q + CAM_IDX_W'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      raw_q <= frame_stamp_i;
      cam_q <= camera_index_i;
    end
    if (state_q == ST_PREP) begin
      stamp_q <= sat_stamp;
    end
    if (state_q == ST_FIND) begin
      if (!slot_rd.used) begin
        sel_slot_q <= idx_q;
      end else if ((idx_q == '0) || alu_sum[ALU_W-1]) begin
        sel_slot_q <= idx_q;
        best_q     <= slot_rd.stamp;
      end
    end
    if (state_q == ST_WRITE) begin
      matched_q <= '0;
      mvalid_q  <= '0;
    end
    // the highest matching slot of a camera wins, so later hits overwrite
    if (state_q == ST_MATCH && hit) begin
      matched_q <= matched_q + MATCH_W'(1);
      if (rd_cam_ok) begin
        mvalid_q[rd_cam_idx]       <= 1'b1;
        member_slot_q[rd_cam_idx]  <= idx_q;
        member_stamp_q[rd_cam_idx] <= slot_rd.stamp;
      end
    end
    if (res_load) begin
      out_q <= res_d;
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = out_q.status;
  assign member_camera_o = out_q.camera;
  assign member_stamp_o  = out_q.stamp;
  assign member_slot_o   = out_q.slot;
  assign bundle_stamp_o  = out_q.bstamp;
  assign last_o          = out_q.last;

endmodule

/* rtl/cfbm_chk.sv */
module cfbm_chk (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [cfbm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input logic [cfbm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic [cfbm_pkg::STAMP_W-1:0]    frame_stamp_i,
  input logic [cfbm_pkg::CAM_W-1:0]      camera_index_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [cfbm_pkg::STATUS_W-1:0]   status_o,
  input logic [cfbm_pkg::CAM_W-1:0]      member_camera_o,
  input logic [cfbm_pkg::STAMP_W-1:0]    member_stamp_o,
  input logic [cfbm_pkg::MSLOT_W-1:0]    member_slot_o,
  input logic [cfbm_pkg::STAMP_W-1:0]    bundle_stamp_o,
  input logic                            last_o
);
  import cfbm_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(member_stamp_o) && $stable(last_o))
    else $error("result changed while stalled");

  // one frame at a time: busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a frame is in progress");

  // anything but a bundle member is a single zero-padded result
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STATUS_MEMBER) |->
    last_o && (member_camera_o == '0) && (bundle_stamp_o == '0))
    else $error("non-member result malformed");

  // bundle members follow each other back to back in camera order
  a_member_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=>
    out_valid_o && (status_o == STATUS_MEMBER) &&
    (member_camera_o == $past(member_camera_o) + CAM_W'(1)))
    else $error("bundle member sequence broken");

endmodule

bind camera_frame_bundle_matcher_core cfbm_chk u_cfbm_chk (.*);
